FILE: src/cbr_pkg.sv
package cbr_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] REG_NUM_LINES     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_LENGTH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_GAIN = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WET_LEVEL     = 2'd3;

    // Register field widths
    localparam int NUM_LINES_W = 4;
    localparam int BASE_LEN_W  = 11;
    localparam int GAIN_W      = 16;
    localparam int WET_W       = 17;

    // Register reset values
    localparam logic [NUM_LINES_W-1:0] NUM_LINES_RST = 4'd4;
    localparam logic [BASE_LEN_W-1:0]  BASE_LEN_RST  = 11'd700;
    localparam logic [GAIN_W-1:0]      GAIN_RST      = 16'd52429;
    localparam logic [WET_W-1:0]       WET_RST       = 17'd32768;

    // Q1.16 unity and rounding half
    localparam logic [WET_W-1:0] WET_UNITY = 17'd65536;
    localparam int               Q16_HALF  = 32768;
    localparam int               Q16_SHIFT = 16;

    // Datapath operations selected by the control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_LOAD,
        OP_LINE_ADDR,
        OP_READ_PREV,
        OP_FB_MUL,
        OP_WRITE_BACK,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_FIX,
        OP_MIX_WET,
        OP_MIX_DRY,
        OP_DONE
    } ucode_op_t;

    // Hold conditions: the step repeats while they block
    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_IN,
        WAIT_OUT
    } wait_cond_t;

    // Branch conditions: taken jumps go to the target, else fall through
    typedef enum logic [2:0] {
        JMP_NEVER,
        JMP_ALWAYS,
        JMP_LINES_LEFT,
        JMP_DIV_LEFT,
        JMP_CLR_LEFT
    } jump_cond_t;

    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] STEP_CLEAR      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_IDLE       = 4'd1;
    localparam logic [STEP_W-1:0] STEP_LINE_ADDR  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_READ_PREV  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_FB_MUL     = 4'd4;
    localparam logic [STEP_W-1:0] STEP_WRITE_BACK = 4'd5;
    localparam logic [STEP_W-1:0] STEP_DIV_INIT   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_DIV_STEP   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DIV_FIX    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_MIX_WET    = 4'd9;
    localparam logic [STEP_W-1:0] STEP_MIX_DRY    = 4'd10;
    localparam logic [STEP_W-1:0] STEP_DONE       = 4'd11;

    typedef struct packed {
        ucode_op_t         op;
        wait_cond_t        wait_on;
        jump_cond_t        jump_on;
        logic [STEP_W-1:0] target;
    } ucode_word_t;

    // Program store
    function automatic ucode_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_word_t w;
        case (step)
            STEP_CLEAR:      w = '{OP_CLEAR,      WAIT_NONE, JMP_CLR_LEFT,   STEP_CLEAR};
            STEP_IDLE:       w = '{OP_LOAD,       WAIT_IN,   JMP_NEVER,      STEP_IDLE};
            STEP_LINE_ADDR:  w = '{OP_LINE_ADDR,  WAIT_NONE, JMP_NEVER,      STEP_IDLE};
            STEP_READ_PREV:  w = '{OP_READ_PREV,  WAIT_NONE, JMP_NEVER,      STEP_IDLE};
            STEP_FB_MUL:     w = '{OP_FB_MUL,     WAIT_NONE, JMP_NEVER,      STEP_IDLE};
            STEP_WRITE_BACK: w = '{OP_WRITE_BACK, WAIT_NONE, JMP_LINES_LEFT, STEP_LINE_ADDR};
            STEP_DIV_INIT:   w = '{OP_DIV_INIT,   WAIT_NONE, JMP_NEVER,      STEP_IDLE};
            STEP_DIV_STEP:   w = '{OP_DIV_STEP,   WAIT_NONE, JMP_DIV_LEFT,   STEP_DIV_STEP};
            STEP_DIV_FIX:    w = '{OP_DIV_FIX,    WAIT_NONE, JMP_NEVER,      STEP_IDLE};
            STEP_MIX_WET:    w = '{OP_MIX_WET,    WAIT_NONE, JMP_NEVER,      STEP_IDLE};
            STEP_MIX_DRY:    w = '{OP_MIX_DRY,    WAIT_NONE, JMP_NEVER,      STEP_IDLE};
            STEP_DONE:       w = '{OP_DONE,       WAIT_OUT,  JMP_ALWAYS,     STEP_IDLE};
            default:         w = '{OP_NOP,        WAIT_NONE, JMP_ALWAYS,     STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: src/comb_bank_reverb_core.sv
// Each sample passes through four delay-memory steps per line, then the one-bit-per-cycle
// divider that averages the lines over SUM_W = SAMPLE_BITS + clog2(MAX_LINES) + 2 bits,
// then the wet/dry mix. A new sample is taken only once the result of the last one has
// been registered at the output.
// Reset: synchronous, active low; a clearing pass then zeroes the delay memory, one entry
// per cycle (all 36864 entries at default sizes), before the first sample is taken.
module comb_bank_reverb_core #(
    parameter int MAX_LINES       = 8,
    parameter int MAX_BASE_LENGTH = 1024,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [cbr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cbr_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // [SAMPLE_BITS-1:0] dry_sample

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata    // [SAMPLE_BITS-1:0] mixed_sample
);

    localparam int SW     = SAMPLE_BITS;
    localparam int DW     = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int DEPTH  = MAX_BASE_LENGTH * MAX_LINES * (MAX_LINES + 1) / 2;
    localparam int AW     = $clog2(DEPTH);
    localparam int PW     = $clog2(MAX_BASE_LENGTH * MAX_LINES);
    localparam int LENW   = PW + 1;
    localparam int BW     = $clog2(MAX_BASE_LENGTH + 1);
    localparam int CW     = $clog2(MAX_LINES + 1);
    localparam int IW     = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int SUMW   = SW + $clog2(MAX_LINES) + 2;
    localparam int DCW    = $clog2(SUMW + 1);
    localparam int PRW    = SW + 18;
    localparam int FBW    = SW + 3;
    localparam int ACCW   = SW + 19;
    localparam int GW     = cbr_pkg::GAIN_W;
    localparam int WW     = cbr_pkg::WET_W;

    // Configuration registers
    logic [cbr_pkg::NUM_LINES_W-1:0] num_lines_reg;
    logic [cbr_pkg::BASE_LEN_W-1:0]  base_length_reg;
    logic [GW-1:0]                   feedback_gain_reg;
    logic [WW-1:0]                   wet_level_reg;

    // Sequencer
    logic [cbr_pkg::STEP_W-1:0] pc_reg, pc_next;
    cbr_pkg::ucode_word_t       uword;
    logic                       stall;
    logic                       jump_take;
    logic                       exec;

    // Per-sample working registers
    logic signed [SW-1:0]   dry_reg;
    logic [CW-1:0]          n_reg;
    logic [BW-1:0]          blen_reg;
    logic [WW-1:0]          w_reg;
    logic [CW-1:0]          idx_reg;
    logic [AW-1:0]          start_reg;
    logic [AW-1:0]          stride_reg;
    logic [LENW-1:0]        len_reg;
    logic [PW-1:0]          pos_reg;
    logic [PW-1:0]          prev_reg;
    logic signed [SW-1:0]   cur_reg;
    logic signed [PRW-1:0]  prod_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic [PW-1:0]          pos_mem_reg [MAX_LINES];
    logic [AW-1:0]          clr_reg;

    // Divider registers
    logic [SUMW-1:0]        quo_reg;
    logic [CW:0]            rem_reg;
    logic [CW:0]            div_reg;
    logic                   neg_reg;
    logic [DCW-1:0]         div_cnt_reg;
    logic signed [SW-1:0]   wet_reg;
    logic signed [ACCW-1:0] acc_reg;

    // Output register
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [SW-1:0]          mixed_reg;

    // Delay memory
    logic [SW-1:0]          mem [DEPTH];
    logic [SW-1:0]          rd_data_reg;
    logic [AW-1:0]          rd_addr;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [SW-1:0]          mem_wdata;

    // Combinational helpers
    logic [CW-1:0]          n_eff;
    logic [BW-1:0]          blen_eff;
    logic [WW-1:0]          w_eff;
    logic [PW-1:0]          pos_raw;
    logic [PW-1:0]          pos_eff;
    logic [PW-1:0]          prev_eff;
    logic [LENW-1:0]        pos_inc;
    logic [PW-1:0]          pos_wrap;
    logic signed [FBW-1:0]  fb_sum;
    logic [SW-1:0]          fb_sat;
    logic signed [SUMW-1:0] div_num;
    logic [CW+1:0]          trial;
    logic [SW-1:0]          quo_lo;
    logic [WW-1:0]          dry_share;
    logic signed [ACCW-16-1:0] mix_shift;
    logic [SW-1:0]          mix_sat;
    logic signed [PRW-1:0]  fb_round;

    // Fetch and sequence
    assign uword = cbr_pkg::ucode_rom(pc_reg);

    always_comb begin
        case (uword.wait_on)
            cbr_pkg::WAIT_IN:  stall = !s_tvalid;
            cbr_pkg::WAIT_OUT: stall = m_tvalid_reg && !m_tready;
            default:           stall = 1'b0;
        endcase
    end

    always_comb begin
        case (uword.jump_on)
            cbr_pkg::JMP_ALWAYS:     jump_take = 1'b1;
            cbr_pkg::JMP_LINES_LEFT:
                jump_take = ((CW+1)'(idx_reg) + (CW+1)'(1)) < (CW+1)'(n_reg);
            cbr_pkg::JMP_DIV_LEFT:   jump_take = div_cnt_reg != '0;
            cbr_pkg::JMP_CLR_LEFT:   jump_take = clr_reg != AW'(DEPTH - 1);
            default:                 jump_take = 1'b0;
        endcase
    end

    assign exec = !stall;

    always_comb begin
        if (stall) begin
            pc_next = pc_reg;
        end else if (jump_take) begin
            pc_next = uword.target;
        end else begin
            pc_next = pc_reg + cbr_pkg::STEP_W'(1);
        end
    end

    assign s_tready = (uword.wait_on == cbr_pkg::WAIT_IN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= cbr_pkg::STEP_CLEAR;
        end else begin
            pc_reg <= pc_next;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_lines_reg     <= cbr_pkg::NUM_LINES_RST;
            base_length_reg   <= cbr_pkg::BASE_LEN_RST;
            feedback_gain_reg <= cbr_pkg::GAIN_RST;
            wet_level_reg     <= cbr_pkg::WET_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cbr_pkg::REG_NUM_LINES:
                    num_lines_reg <= cfg_data[cbr_pkg::NUM_LINES_W-1:0];
                cbr_pkg::REG_BASE_LENGTH:
                    base_length_reg <= cfg_data[cbr_pkg::BASE_LEN_W-1:0];
                cbr_pkg::REG_FEEDBACK_GAIN:
                    feedback_gain_reg <= cfg_data[GW-1:0];
                cbr_pkg::REG_WET_LEVEL:
                    wet_level_reg <= cfg_data[WW-1:0];
                default: ;
            endcase
        end
    end

    // Clamp configuration at sample start
    always_comb begin
        if (num_lines_reg == '0) begin
            n_eff = CW'(1);
        end else if (32'(num_lines_reg) > 32'(MAX_LINES)) begin
            n_eff = CW'(MAX_LINES);
        end else begin
            n_eff = CW'(num_lines_reg);
        end
        if (base_length_reg == '0) begin
            blen_eff = BW'(1);
        end else if (32'(base_length_reg) > 32'(MAX_BASE_LENGTH)) begin
            blen_eff = BW'(MAX_BASE_LENGTH);
        end else begin
            blen_eff = BW'(base_length_reg);
        end
        w_eff = (wet_level_reg > cbr_pkg::WET_UNITY) ? cbr_pkg::WET_UNITY : wet_level_reg;
    end

    // Line position: wrap stale positions, find the previous entry
    always_comb begin
        pos_raw  = pos_mem_reg[idx_reg[IW-1:0]];
        pos_eff  = (LENW'(pos_raw) >= len_reg) ? '0 : pos_raw;
        prev_eff = (pos_eff == '0) ? PW'(len_reg - LENW'(1)) : pos_eff - PW'(1);
        pos_inc  = LENW'(pos_reg) + LENW'(1);
        pos_wrap = (pos_inc >= len_reg) ? '0 : PW'(pos_inc);
    end

    // Feedback: round, add dry, saturate
    always_comb begin
        fb_round = prod_reg + PRW'(cbr_pkg::Q16_HALF);
        fb_sum   = FBW'(dry_reg) + FBW'($signed(fb_round[PRW-1:cbr_pkg::Q16_SHIFT]));
        if (fb_sum[FBW-1:SW-1] == '0 || fb_sum[FBW-1:SW-1] == '1) begin
            fb_sat = fb_sum[SW-1:0];
        end else if (fb_sum[FBW-1]) begin
            fb_sat = {1'b1, {(SW-1){1'b0}}};
        end else begin
            fb_sat = {1'b0, {(SW-1){1'b1}}};
        end
    end

    // Divider helpers
    always_comb begin
        div_num = sum_reg + SUMW'(n_reg);
        trial   = {rem_reg, quo_reg[SUMW-1]};
        quo_lo  = quo_reg[SW-1:0];
    end

    // Mix helpers
    always_comb begin
        dry_share = cbr_pkg::WET_UNITY - w_reg;
        mix_shift = acc_reg[ACCW-1:cbr_pkg::Q16_SHIFT];
        if (mix_shift[ACCW-17:SW-1] == '0 || mix_shift[ACCW-17:SW-1] == '1) begin
            mix_sat = mix_shift[SW-1:0];
        end else if (mix_shift[ACCW-17]) begin
            mix_sat = {1'b1, {(SW-1){1'b0}}};
        end else begin
            mix_sat = {1'b0, {(SW-1){1'b1}}};
        end
    end

    // Memory port selection
    always_comb begin
        rd_addr   = start_reg + AW'(pos_eff);
        mem_we    = 1'b0;
        mem_waddr = start_reg + AW'(pos_reg);
        mem_wdata = fb_sat;
        case (uword.op)
            cbr_pkg::OP_READ_PREV: begin
                rd_addr = start_reg + AW'(prev_reg);
            end
            cbr_pkg::OP_WRITE_BACK: begin
                mem_we = 1'b1;
            end
            cbr_pkg::OP_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            default: ;
        endcase
    end

    // Delay memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Control counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
            for (int i = 0; i < MAX_LINES; i++) begin
                pos_mem_reg[i] <= '0;
            end
        end else if (exec) begin
            case (uword.op)
                cbr_pkg::OP_CLEAR:      clr_reg <= clr_reg + AW'(1);
                cbr_pkg::OP_WRITE_BACK: pos_mem_reg[idx_reg[IW-1:0]] <= pos_wrap;
                default: ;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (exec) begin
            case (uword.op)
                cbr_pkg::OP_LOAD: begin
                    dry_reg    <= s_tdata[SW-1:0];
                    n_reg      <= n_eff;
                    blen_reg   <= blen_eff;
                    w_reg      <= w_eff;
                    idx_reg    <= '0;
                    start_reg  <= '0;
                    stride_reg <= AW'(MAX_BASE_LENGTH);
                    len_reg    <= LENW'(blen_eff);
                    sum_reg    <= '0;
                end
                cbr_pkg::OP_LINE_ADDR: begin
                    pos_reg  <= pos_eff;
                    prev_reg <= prev_eff;
                end
                cbr_pkg::OP_READ_PREV: begin
                    cur_reg <= rd_data_reg;
                end
                cbr_pkg::OP_FB_MUL: begin
                    prod_reg <= PRW'($signed({1'b0, feedback_gain_reg})) * PRW'(cur_reg);
                    sum_reg  <= sum_reg + SUMW'(cur_reg)
                                + SUMW'($signed(rd_data_reg));
                end
                cbr_pkg::OP_WRITE_BACK: begin
                    idx_reg    <= idx_reg + CW'(1);
                    start_reg  <= start_reg + stride_reg;
                    stride_reg <= stride_reg + AW'(MAX_BASE_LENGTH);
                    len_reg    <= len_reg + LENW'(blen_reg);
                end
                cbr_pkg::OP_DIV_INIT: begin
                    neg_reg     <= div_num[SUMW-1];
                    quo_reg     <= div_num[SUMW-1] ? SUMW'(-div_num) : SUMW'(div_num);
                    rem_reg     <= '0;
                    div_reg     <= {n_reg, 1'b0};
                    div_cnt_reg <= DCW'(SUMW - 1);
                end
                cbr_pkg::OP_DIV_STEP: begin
                    if (trial >= {1'b0, div_reg}) begin
                        rem_reg <= (CW+1)'(trial - {1'b0, div_reg});
                        quo_reg <= {quo_reg[SUMW-2:0], 1'b1};
                    end else begin
                        rem_reg <= trial[CW:0];
                        quo_reg <= {quo_reg[SUMW-2:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg - DCW'(1);
                end
                cbr_pkg::OP_DIV_FIX: begin
                    if (!neg_reg) begin
                        wet_reg <= quo_lo;
                    end else if (rem_reg != '0) begin
                        wet_reg <= ~quo_lo;
                    end else begin
                        wet_reg <= -quo_lo;
                    end
                end
                cbr_pkg::OP_MIX_WET: begin
                    acc_reg <= ACCW'(wet_reg) * ACCW'($signed({1'b0, w_reg}));
                end
                cbr_pkg::OP_MIX_DRY: begin
                    acc_reg <= acc_reg + ACCW'(dry_reg) * ACCW'($signed({1'b0, dry_share}))
                               + ACCW'(cbr_pkg::Q16_HALF);
                end
                cbr_pkg::OP_DONE: begin
                    mixed_reg <= mix_sat;
                end
                default: ;
            endcase
        end
    end

    // Output transfer register
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (exec && uword.op == cbr_pkg::OP_DONE) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DW'(mixed_reg);

endmodule

FILE: bench/comb_bank_reverb_core_tb.sv
`timescale 1ns / 100ps

module comb_bank_reverb_core_tb;

    localparam int     LINES_MAX    = 8;
    localparam int     BASE_MAX     = 1024;
    localparam int     ECHO_DEPTH   = BASE_MAX * LINES_MAX * (LINES_MAX + 1) / 2;
    localparam longint SAMPLE_TOP   = 32767;
    localparam longint SAMPLE_FLOOR = -32768;
    localparam longint Q16_ONE      = 65536;
    localparam int     DRAIN_CYCLES = 80;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [cbr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [cbr_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [15:0]                     s_tdata   = '0;   // [15:0] dry_sample
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [15:0]                     m_tdata;          // [15:0] mixed_sample

    // Predictor state: delay lines, tap positions and register copies
    logic signed [15:0] echo_mem [ECHO_DEPTH];
    int                 tap_pos [LINES_MAX];
    logic [cbr_pkg::NUM_LINES_W-1:0] mir_lines;
    logic [cbr_pkg::BASE_LEN_W-1:0]  mir_base;
    logic [cbr_pkg::GAIN_W-1:0]      mir_gain;
    logic [cbr_pkg::WET_W-1:0]       mir_wet;

    logic [15:0]        dry_backlog [$];
    logic signed [15:0] pending_mix [$];
    int                 in_flight = 0;
    int                 faults    = 0;
    int                 in_gap    = 0;
    int                 out_hold  = 0;
    bit                 dry_taken = 1'b0;
    bit                 calm      = 1'b0;

    comb_bank_reverb_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > SAMPLE_TOP) return 16'sh7fff;
        if (v < SAMPLE_FLOOR) return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic longint floor_quot(input longint a, input longint d);
        longint q;
        q = a / d;
        if ((a % d != 0) && (a < 0)) q = q - 1;
        return q;
    endfunction

    // Run one sample through the comb bank, updating lines and positions
    function automatic logic signed [15:0] reverb_sample(input logic signed [15:0] dry);
        int     n, blen, lane, origin, span, pos, prv;
        longint w, acc, cur, old, fb, wet, mix;
        n = int'(mir_lines);
        if (n < 1) n = 1;
        if (n > LINES_MAX) n = LINES_MAX;
        blen = int'(mir_base);
        if (blen < 1) blen = 1;
        if (blen > BASE_MAX) blen = BASE_MAX;
        w = longint'(mir_wet);
        if (w > Q16_ONE) w = Q16_ONE;
        acc = 0;
        for (lane = 0; lane < n; lane++) begin
            origin = BASE_MAX * (lane * (lane + 1) / 2);
            span   = blen * (lane + 1);
            pos    = tap_pos[lane];
            // a line shortened under its position restarts at zero
            if (pos >= span) pos = 0;
            prv = (pos == 0) ? span - 1 : pos - 1;
            cur = longint'(echo_mem[origin + pos]);
            old = longint'(echo_mem[origin + prv]);
            acc = acc + cur + old;
            fb  = (longint'(mir_gain) * cur + cbr_pkg::Q16_HALF) >>> cbr_pkg::Q16_SHIFT;
            echo_mem[origin + pos] = clamp16(dry + fb);
            pos++;
            if (pos >= span) pos = 0;
            tap_pos[lane] = pos;
        end
        wet = floor_quot(acc + n, longint'(2 * n));
        mix = (wet * w + dry * (Q16_ONE - w) + cbr_pkg::Q16_HALF) >>> cbr_pkg::Q16_SHIFT;
        return clamp16(mix);
    endfunction

    // Track register writes, predict on each input transfer, check each output transfer
    always @(posedge aclk) begin
        logic signed [15:0] want;
        if (!aresetn) begin
            foreach (echo_mem[i]) echo_mem[i] = '0;
            foreach (tap_pos[i]) tap_pos[i] = 0;
            mir_lines = cbr_pkg::NUM_LINES_RST;
            mir_base  = cbr_pkg::BASE_LEN_RST;
            mir_gain  = cbr_pkg::GAIN_RST;
            mir_wet   = cbr_pkg::WET_RST;
            dry_taken = 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    cbr_pkg::REG_NUM_LINES:
                        mir_lines = cfg_data[cbr_pkg::NUM_LINES_W-1:0];
                    cbr_pkg::REG_BASE_LENGTH:
                        mir_base  = cfg_data[cbr_pkg::BASE_LEN_W-1:0];
                    cbr_pkg::REG_FEEDBACK_GAIN:
                        mir_gain  = cfg_data[cbr_pkg::GAIN_W-1:0];
                    cbr_pkg::REG_WET_LEVEL:
                        mir_wet   = cfg_data[cbr_pkg::WET_W-1:0];
                    default: ;
                endcase
            end
            dry_taken = s_tvalid && s_tready;
            if (dry_taken) pending_mix = {pending_mix, reverb_sample(s_tdata[15:0])};
            if (m_tvalid && m_tready) begin
                if (pending_mix.size() == 0) begin
                    faults++;
                    $display("%0t unexpected mixed_sample: expected none, actual %0d",
                             $time, $signed(m_tdata[15:0]));
                end else begin
                    want = pending_mix.pop_front();
                    in_flight--;
                    if (m_tdata[15:0] !== want) begin
                        faults++;
                        $display("%0t mixed_sample mismatch: expected %0d, actual %0d",
                                 $time, want, $signed(m_tdata[15:0]));
                    end
                end
            end
        end
    end

    // Present queued samples; hold until transfer, idle in short random bursts
    always @(negedge aclk) begin
        logic go;
        go = 1'b0;
        if (!aresetn) begin
            go = 1'b0;
        end else if (s_tvalid && !dry_taken) begin
            go = 1'b1;
        end else if (in_gap > 0) begin
            in_gap--;
        end else if (dry_backlog.size() != 0) begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                in_gap = $urandom_range(0, 3);
            end else begin
                go = 1'b1;
                s_tdata <= dry_backlog.pop_front();
            end
        end
        s_tvalid <= go;
    end

    // Stall the result side in short random bursts
    always @(negedge aclk) begin
        if (!aresetn || calm) begin
            m_tready <= 1'b1;
        end else if (out_hold > 0) begin
            out_hold--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            out_hold = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic queue_dry(input logic [15:0] v);
        dry_backlog = {dry_backlog, v};
        in_flight++;
    endtask

    task automatic write_reg(input logic [cbr_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [cbr_pkg::CFG_DATA_W-1:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait for the bank to go quiet, then load all four registers
    task automatic set_bank(input logic [cbr_pkg::CFG_DATA_W-1:0] lines,
                            input logic [cbr_pkg::CFG_DATA_W-1:0] base,
                            input logic [cbr_pkg::CFG_DATA_W-1:0] gain,
                            input logic [cbr_pkg::CFG_DATA_W-1:0] wet);
        wait (in_flight == 0);
        repeat ($urandom_range(2, 8)) @(negedge aclk);
        write_reg(cbr_pkg::REG_NUM_LINES, lines);
        write_reg(cbr_pkg::REG_BASE_LENGTH, base);
        write_reg(cbr_pkg::REG_FEEDBACK_GAIN, gain);
        write_reg(cbr_pkg::REG_WET_LEVEL, wet);
    endtask

    initial begin
        int                 ph, k, sel;
        logic [16:0]        lines, base, gain, wet;
        logic signed [15:0] dry;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: sample extremes and sign boundaries
        queue_dry(16'h7fff);
        queue_dry(16'h8000);
        queue_dry(16'h0000);
        queue_dry(16'hffff);
        queue_dry(16'h0001);

        // One line of length one, full feedback, all wet: drive feedback into saturation
        set_bank(17'd1, 17'd1, 17'd65535, 17'd65536);
        repeat (3) queue_dry(16'h7fff);
        repeat (3) queue_dry(16'h8000);
        queue_dry(16'h0000);
        queue_dry(16'h0001);

        // Zero line count and zero length, upper data bits set; no feedback, all dry
        set_bank(17'h1fff0, 17'h1f800, 17'd0, 17'd0);
        queue_dry(16'd100);
        queue_dry(-16'sd100);
        queue_dry(16'h7fff);
        queue_dry(16'h8000);

        // Oversized count, length and wet level
        set_bank(17'd15, 17'd2047, 17'd32768, 17'h1ffff);
        queue_dry(16'h8000);
        queue_dry(16'h7fff);
        queue_dry(16'd12345);
        queue_dry(16'hffff);
        queue_dry(16'h0000);

        // Shrink the lines below their current positions; wet just above one
        set_bank(17'd8, 17'd2, 17'd40000, 17'd65537);
        queue_dry(16'h5555);
        queue_dry(16'haaaa);
        queue_dry(16'h7fff);
        queue_dry(16'h8000);
        queue_dry(16'h0101);

        // Random settings, mostly short lines so the feedback recirculates
        dry = '0;
        for (ph = 0; ph < 12; ph++) begin
            lines = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(0, 15))
                                                : 17'($urandom_range(1, 8));
            base  = ($urandom_range(0, 7) == 0) ? 17'($urandom_range(0, 2047))
                                                : 17'($urandom_range(1, 24));
            case ($urandom_range(0, 3))
                0:       gain = 17'd0;
                1:       gain = 17'd65535;
                default: gain = 17'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 4))
                0:       wet = 17'd0;
                1:       wet = 17'd65536;
                2:       wet = 17'($urandom_range(65537, 131071));
                default: wet = 17'($urandom_range(0, 65536));
            endcase
            // stray upper bits on the data bus are dropped by the register
            set_bank({13'($urandom), lines[3:0]}, {6'($urandom), base[10:0]},
                     {1'($urandom), gain[15:0]}, wet);
            if (ph == 10) calm = 1'b1;
            for (k = 0; k < 77; k++) begin
                sel = $urandom_range(0, 9);
                if (sel < 6) dry = 16'($urandom);
                else if (sel < 8) dry = 16'($urandom_range(0, 1023) - 512);
                else if (sel == 8) dry = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                // otherwise repeat the last sample to build up a steady level
                queue_dry(dry);
            end
        end

        wait (in_flight == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (faults == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run, clearing pass included
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
